// ===== hw/rtl/lfmt_pkg.sv =====
package lfmt_pkg;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef enum logic [2:0] {
      CSR_PWM_PERIOD       = 3'd0,
      CSR_STOP_THRESHOLD   = 3'd1,
      CSR_RANGE_MIN        = 3'd2,
      CSR_RANGE_MAX        = 3'd3,
      CSR_RANGE_INTERVAL   = 3'd4,
      CSR_CONTROL_INTERVAL = 3'd5,
      CSR_RECOVERY_LIMIT   = 3'd6
   } csr_index_type;

   localparam int CsrDataWidth = 10;

   localparam logic [7:0] PWM_PERIOD_RESET       = 8'd100;
   localparam logic [8:0] STOP_THRESHOLD_RESET   = 9'd20;
   localparam logic [8:0] RANGE_MIN_RESET        = 9'd2;
   localparam logic [8:0] RANGE_MAX_RESET        = 9'd400;
   localparam logic [9:0] RANGE_INTERVAL_RESET   = 10'd100;
   localparam logic [3:0] CONTROL_INTERVAL_RESET = 4'd2;
   localparam logic [9:0] RECOVERY_LIMIT_RESET   = 10'd500;

   // dur / 58 == (dur >> 1) / 29 == ((dur >> 1) * 36158) >> 20, exact for 15-bit values
   localparam logic [15:0] DIV29_RECIP = 16'd36158;
   localparam int          DIV29_SHIFT = 20;

   localparam logic [10:0] LOST_MAX = 11'h7FF;

   localparam logic [2:0] LINE_LEFT  = 3'b100;
   localparam logic [2:0] LINE_RIGHT = 3'b001;

   localparam logic [6:0] DUTY_OFF    = 7'd0;
   localparam logic [6:0] DUTY_CRAWL  = 7'd40;
   localparam logic [6:0] DUTY_SEARCH = 7'd50;
   localparam logic [6:0] DUTY_60     = 7'd60;
   localparam logic [6:0] DUTY_70     = 7'd70;
   localparam logic [6:0] DUTY_75     = 7'd75;
   localparam logic [6:0] DUTY_80     = 7'd80;
   localparam logic [6:0] DUTY_85     = 7'd85;

   typedef struct packed {
      dir_type    left_dir;
      logic [6:0] left_duty;
      dir_type    right_dir;
      logic [6:0] right_duty;
   } drive_type;

   function automatic drive_type make_drive(dir_type ld, logic [6:0] lduty,
                                            dir_type rd, logic [6:0] rduty);
      drive_type d;
      d.left_dir   = ld;
      d.left_duty  = lduty;
      d.right_dir  = rd;
      d.right_duty = rduty;
      return d;
   endfunction

   function automatic drive_type steer_table(logic [2:0] line, logic [2:0] last_line);
      drive_type d;
      case (line)
         3'd0: begin
            if (last_line == 3'd0) begin
               d = make_drive(DIR_FWD, DUTY_CRAWL, DIR_FWD, DUTY_CRAWL);
            end else if ((last_line & LINE_LEFT) != 3'd0) begin
               d = make_drive(DIR_REV, DUTY_70, DIR_FWD, DUTY_70);
            end else if ((last_line & LINE_RIGHT) != 3'd0) begin
               d = make_drive(DIR_FWD, DUTY_70, DIR_REV, DUTY_70);
            end else begin
               d = make_drive(DIR_FWD, DUTY_60, DIR_FWD, DUTY_60);
            end
         end
         3'd2:    d = make_drive(DIR_FWD, DUTY_80, DIR_FWD, DUTY_80);
         3'd4:    d = make_drive(DIR_REV, DUTY_70, DIR_FWD, DUTY_80);
         3'd1:    d = make_drive(DIR_FWD, DUTY_80, DIR_REV, DUTY_70);
         3'd6:    d = make_drive(DIR_STOP, DUTY_OFF, DIR_FWD, DUTY_85);
         3'd3:    d = make_drive(DIR_FWD, DUTY_85, DIR_STOP, DUTY_OFF);
         3'd5:    d = make_drive(DIR_REV, DUTY_60, DIR_FWD, DUTY_75);
         default: d = make_drive(DIR_FWD, DUTY_70, DIR_FWD, DUTY_70);
      endcase
      return d;
   endfunction

endpackage

// ===== hw/rtl/line_follow_motor_tick_top.sv =====
// Channel   Direction  Handshake              Contents
// req_*     in         req_valid / req_ready  two sensor samples, echo start/end, echo ok
// rsp_*     out        rsp_valid / rsp_ready  four bridge pins, obstacle, distance, strobe
// csr_*     in         csr_write_enable       register index and write data
//
// One beat per cycle while the result side accepts; each beat is held in the input register
// and then in the result register.
// The input register holds the echo duration and the combined line; the divide by 58
// is one 15x16 reciprocal multiply in the tick stage.
// Synchronous reset clears all tick state and loads the register defaults.
// A stalled result holds the tick stage; the input register still takes a beat when empty.
module line_follow_motor_tick_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [2:0]                             req_sensor_sample_a,
   input  logic [2:0]                             req_sensor_sample_b,
   input  logic [15:0]                            req_echo_start,
   input  logic [15:0]                            req_echo_end,
   input  logic                                   req_echo_ok,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_left_forward,
   output logic                                   rsp_left_reverse,
   output logic                                   rsp_right_forward,
   output logic                                   rsp_right_reverse,
   output logic                                   rsp_obstacle,
   output logic [8:0]                             rsp_distance_out,
   output logic                                   rsp_range_strobe,
   input  logic                                   csr_write_enable,
   input  lfmt_pkg::csr_index_type                csr_index,
   input  logic [lfmt_pkg::CsrDataWidth-1:0]      csr_write_data
);
   import lfmt_pkg::*;

   logic [7:0] pwm_period_ff;
   logic [8:0] stop_threshold_ff;
   logic [8:0] range_min_ff;
   logic [8:0] range_max_ff;
   logic [9:0] range_interval_ff;
   logic [3:0] control_interval_ff;
   logic [9:0] recovery_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff       <= PWM_PERIOD_RESET;
         stop_threshold_ff   <= STOP_THRESHOLD_RESET;
         range_min_ff        <= RANGE_MIN_RESET;
         range_max_ff        <= RANGE_MAX_RESET;
         range_interval_ff   <= RANGE_INTERVAL_RESET;
         control_interval_ff <= CONTROL_INTERVAL_RESET;
         recovery_limit_ff   <= RECOVERY_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PWM_PERIOD:       pwm_period_ff       <= csr_write_data[7:0];
            CSR_STOP_THRESHOLD:   stop_threshold_ff   <= csr_write_data[8:0];
            CSR_RANGE_MIN:        range_min_ff        <= csr_write_data[8:0];
            CSR_RANGE_MAX:        range_max_ff        <= csr_write_data[8:0];
            CSR_RANGE_INTERVAL:   range_interval_ff   <= csr_write_data[9:0];
            CSR_CONTROL_INTERVAL: control_interval_ff <= csr_write_data[3:0];
            CSR_RECOVERY_LIMIT:   recovery_limit_ff   <= csr_write_data[9:0];
            default: ;
         endcase
      end
   end

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [15:0] dur_ff;
   logic        echo_ok_ff;
   logic [2:0]  line_ff;
   logic        advance;
   logic        fire;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign fire      = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // wrapped duration: end - start, one less when the timer wrapped
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         dur_ff     <= req_echo_end - req_echo_start
                       - 16'(req_echo_end < req_echo_start);
         echo_ok_ff <= req_echo_ok;
         line_ff    <= ~(req_sensor_sample_a & req_sensor_sample_b);
      end
   end

   // tick state
   logic [7:0]  pwm_pos_ff, pwm_pos_in;
   logic [9:0]  range_count_ff, range_count_in;
   logic [3:0]  control_count_ff, control_count_in;
   logic [10:0] lost_count_ff, lost_count_in;
   logic [2:0]  last_line_ff, last_line_in;
   drive_type   drive_ff, drive_in;
   logic [8:0]  distance_ff, distance_in;
   logic        obstacle_ff, obstacle_in;
   logic        strobe;

   logic [9:0]  range_inc;
   logic [3:0]  control_inc;
   logic [7:0]  pwm_inc;
   logic [30:0] product;
   logic [10:0] cm;
   logic [8:0]  cm_checked;
   logic [10:0] lost_sat;
   logic        lf, lr, rf, rr;

   assign product = 31'(dur_ff[15:1]) * 31'(DIV29_RECIP);
   assign cm      = product[DIV29_SHIFT +: 11];

   always_comb begin
      if (!echo_ok_ff || cm < 11'(range_min_ff) || cm > 11'(range_max_ff)) begin
         cm_checked = 9'd0;
      end else begin
         cm_checked = cm[8:0];
      end
   end

   always_comb begin
      range_inc        = range_count_ff + 10'd1;
      control_inc      = control_count_ff + 4'd1;
      pwm_inc          = pwm_pos_ff + 8'd1;
      lost_sat         = (lost_count_ff != LOST_MAX) ? lost_count_ff + 11'd1 : lost_count_ff;

      range_count_in   = range_inc;
      distance_in      = distance_ff;
      obstacle_in      = obstacle_ff;
      strobe           = 1'b0;
      if (range_inc >= range_interval_ff) begin
         range_count_in = 10'd0;
         strobe         = 1'b1;
         distance_in    = cm_checked;
         obstacle_in    = (cm_checked != 9'd0) && (cm_checked < stop_threshold_ff);
      end

      control_count_in = control_inc;
      drive_in         = drive_ff;
      last_line_in     = last_line_ff;
      lost_count_in    = lost_count_ff;
      if (control_inc >= control_interval_ff) begin
         control_count_in = 4'd0;
         if (obstacle_in) begin
            drive_in = make_drive(DIR_STOP, DUTY_OFF, DIR_STOP, DUTY_OFF);
         end else begin
            drive_in = steer_table(line_ff, last_line_ff);
            if (line_ff != 3'd0) begin
               last_line_in = line_ff;
            end
         end
         if (line_ff != 3'd0) begin
            lost_count_in = 11'd0;
         end else begin
            lost_count_in = lost_sat;
            if (lost_sat > 11'(recovery_limit_ff)) begin
               drive_in = make_drive(DIR_REV, DUTY_SEARCH, DIR_FWD, DUTY_SEARCH);
            end
         end
      end

      lf = (drive_in.left_dir == DIR_FWD) && (pwm_pos_ff < 8'(drive_in.left_duty));
      lr = (drive_in.left_dir == DIR_REV) && (pwm_pos_ff < 8'(drive_in.left_duty));
      rf = (drive_in.right_dir == DIR_FWD) && (pwm_pos_ff < 8'(drive_in.right_duty));
      rr = (drive_in.right_dir == DIR_REV) && (pwm_pos_ff < 8'(drive_in.right_duty));

      pwm_pos_in = (pwm_inc >= pwm_period_ff) ? 8'd0 : pwm_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_pos_ff       <= 8'd0;
         range_count_ff   <= 10'd0;
         control_count_ff <= 4'd0;
         lost_count_ff    <= 11'd0;
         last_line_ff     <= 3'd0;
         drive_ff         <= make_drive(DIR_STOP, DUTY_OFF, DIR_STOP, DUTY_OFF);
         distance_ff      <= 9'd0;
         obstacle_ff      <= 1'b0;
      end else if (fire) begin
         pwm_pos_ff       <= pwm_pos_in;
         range_count_ff   <= range_count_in;
         control_count_ff <= control_count_in;
         lost_count_ff    <= lost_count_in;
         last_line_ff     <= last_line_in;
         drive_ff         <= drive_in;
         distance_ff      <= distance_in;
         obstacle_ff      <= obstacle_in;
      end
   end

   // result register
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_left_forward  <= lf;
         rsp_left_reverse  <= lr;
         rsp_right_forward <= rf;
         rsp_right_reverse <= rr;
         rsp_obstacle      <= obstacle_in;
         rsp_distance_out  <= distance_in;
         rsp_range_strobe  <= strobe;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== test/line_follow_motor_tick_top_tb.sv =====
module line_follow_motor_tick_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfmt_pkg::*;

   localparam int CycleLimit = 200000;

   typedef struct packed {
      logic [2:0]  sample_a;
      logic [2:0]  sample_b;
      logic [15:0] echo_start;
      logic [15:0] echo_end;
      logic        echo_ok;
   } tick_req_type;

   typedef struct packed {
      logic       left_fwd;
      logic       left_rev;
      logic       right_fwd;
      logic       right_rev;
      logic       obstacle;
      logic [8:0] distance;
      logic       strobe;
   } pin_rsp_type;

   typedef struct packed {
      logic [7:0] pwm_period;
      logic [8:0] stop_cm;
      logic [8:0] min_cm;
      logic [8:0] max_cm;
      logic [9:0] range_every;
      logic [3:0] steer_every;
      logic [9:0] lost_limit;
   } tick_cfg_type;

   class bridge_pin_tracker_type;
      logic [7:0]  pwm_period;
      logic [8:0]  stop_cm;
      logic [8:0]  min_cm;
      logic [8:0]  max_cm;
      logic [9:0]  range_every;
      logic [3:0]  steer_every;
      logic [9:0]  lost_limit;
      logic [7:0]  pwm_pos;
      logic [9:0]  range_cnt;
      logic [3:0]  steer_cnt;
      logic [10:0] lost_cnt;
      logic [2:0]  seen_line;
      dir_type     left_dir;
      dir_type     right_dir;
      logic [6:0]  left_duty;
      logic [6:0]  right_duty;
      logic [8:0]  distance;
      logic        obstacle;
      pin_rsp_type pin_queue[$];
      int          pin_errors;
      int          ticks;
      int          strobes;
      int          blocked;
      int          spins;

      function new();
         pwm_period  = PWM_PERIOD_RESET;
         stop_cm     = STOP_THRESHOLD_RESET;
         min_cm      = RANGE_MIN_RESET;
         max_cm      = RANGE_MAX_RESET;
         range_every = RANGE_INTERVAL_RESET;
         steer_every = CONTROL_INTERVAL_RESET;
         lost_limit  = RECOVERY_LIMIT_RESET;
         pwm_pos     = '0;
         range_cnt   = '0;
         steer_cnt   = '0;
         lost_cnt    = '0;
         seen_line   = '0;
         left_dir    = DIR_STOP;
         right_dir   = DIR_STOP;
         left_duty   = DUTY_OFF;
         right_duty  = DUTY_OFF;
         distance    = '0;
         obstacle    = 1'b0;
      endfunction

      function void set_reg(csr_index_type idx, logic [9:0] v);
         case (idx)
            CSR_PWM_PERIOD:       pwm_period  = v[7:0];
            CSR_STOP_THRESHOLD:   stop_cm     = v[8:0];
            CSR_RANGE_MIN:        min_cm      = v[8:0];
            CSR_RANGE_MAX:        max_cm      = v[8:0];
            CSR_RANGE_INTERVAL:   range_every = v;
            CSR_CONTROL_INTERVAL: steer_every = v[3:0];
            CSR_RECOVERY_LIMIT:   lost_limit  = v;
            default: ;
         endcase
      endfunction

      function void set_drive(dir_type ld, logic [6:0] lduty, dir_type rd, logic [6:0] rduty);
         left_dir   = ld;
         left_duty  = lduty;
         right_dir  = rd;
         right_duty = rduty;
      endfunction

      function logic [8:0] echo_cm(tick_req_type t);
         int dur;
         int cm;
         if (!t.echo_ok) return '0;
         if (t.echo_end >= t.echo_start) dur = int'(t.echo_end) - int'(t.echo_start);
         else dur = int'(16'hFFFF) - int'(t.echo_start) + int'(t.echo_end);
         cm = dur / 58;
         if (cm < int'(min_cm) || cm > int'(max_cm)) return '0;
         return cm[8:0];
      endfunction

      function void steer(logic [2:0] line);
         if (obstacle) begin
            set_drive(DIR_STOP, DUTY_OFF, DIR_STOP, DUTY_OFF);
            return;
         end
         case (line)
            3'd0: begin
               if (seen_line == 3'd0) set_drive(DIR_FWD, DUTY_CRAWL, DIR_FWD, DUTY_CRAWL);
               else if (seen_line[2]) set_drive(DIR_REV, DUTY_70, DIR_FWD, DUTY_70);
               else if (seen_line[0]) set_drive(DIR_FWD, DUTY_70, DIR_REV, DUTY_70);
               else set_drive(DIR_FWD, DUTY_60, DIR_FWD, DUTY_60);
            end
            3'd1:    set_drive(DIR_FWD, DUTY_80, DIR_REV, DUTY_70);
            3'd2:    set_drive(DIR_FWD, DUTY_80, DIR_FWD, DUTY_80);
            3'd3:    set_drive(DIR_FWD, DUTY_85, DIR_STOP, DUTY_OFF);
            3'd4:    set_drive(DIR_REV, DUTY_70, DIR_FWD, DUTY_80);
            3'd5:    set_drive(DIR_REV, DUTY_60, DIR_FWD, DUTY_75);
            3'd6:    set_drive(DIR_STOP, DUTY_OFF, DIR_FWD, DUTY_85);
            default: set_drive(DIR_FWD, DUTY_70, DIR_FWD, DUTY_70);
         endcase
         if (line != 3'd0) seen_line = line;
      endfunction

      function void take_tick(tick_req_type t);
         pin_rsp_type p;
         logic [2:0]  line;
         p = '0;
         range_cnt = range_cnt + 10'd1;
         if (range_cnt >= range_every) begin
            range_cnt = '0;
            p.strobe  = 1'b1;
            strobes++;
            distance  = echo_cm(t);
            obstacle  = (distance != '0) && (distance < stop_cm);
         end
         line = ~(t.sample_a & t.sample_b);
         steer_cnt = steer_cnt + 4'd1;
         if (steer_cnt >= steer_every) begin
            steer_cnt = '0;
            steer(line);
            if (obstacle) blocked++;
            if (line != 3'd0) begin
               lost_cnt = '0;
            end else begin
               if (lost_cnt != LOST_MAX) lost_cnt = lost_cnt + 11'd1;
               if (lost_cnt > lost_limit) begin
                  set_drive(DIR_REV, DUTY_SEARCH, DIR_FWD, DUTY_SEARCH);
                  spins++;
               end
            end
         end
         if (left_dir == DIR_FWD) p.left_fwd = (pwm_pos < left_duty);
         else if (left_dir == DIR_REV) p.left_rev = (pwm_pos < left_duty);
         if (right_dir == DIR_FWD) p.right_fwd = (pwm_pos < right_duty);
         else if (right_dir == DIR_REV) p.right_rev = (pwm_pos < right_duty);
         p.obstacle = obstacle;
         p.distance = distance;
         pwm_pos = pwm_pos + 8'd1;
         if (pwm_pos >= pwm_period) pwm_pos = '0;
         pin_queue.push_back(p);
         ticks++;
      endfunction

      function void match_pins(pin_rsp_type got);
         pin_rsp_type want;
         string       bad;
         if (pin_queue.size() == 0) begin
            pin_errors++;
            if (pin_errors <= 10) begin
               $display("unexpected result beat: lf=%0b lr=%0b rf=%0b rr=%0b obst=%0b dist=%0d stb=%0b",
                        got.left_fwd, got.left_rev, got.right_fwd, got.right_rev,
                        got.obstacle, got.distance, got.strobe);
            end
            return;
         end
         want = pin_queue.pop_front();
         bad  = "";
         if (got.left_fwd !== want.left_fwd) bad = {bad, " left_forward"};
         if (got.left_rev !== want.left_rev) bad = {bad, " left_reverse"};
         if (got.right_fwd !== want.right_fwd) bad = {bad, " right_forward"};
         if (got.right_rev !== want.right_rev) bad = {bad, " right_reverse"};
         if (got.obstacle !== want.obstacle) bad = {bad, " obstacle"};
         if (got.distance !== want.distance) bad = {bad, " distance_out"};
         if (got.strobe !== want.strobe) bad = {bad, " range_strobe"};
         if (bad != "") begin
            pin_errors++;
            if (pin_errors <= 10) begin
               $display("mismatch at %0t on%s", $realtime, bad);
               $display("  expected lf=%0b lr=%0b rf=%0b rr=%0b obst=%0b dist=%0d stb=%0b",
                        want.left_fwd, want.left_rev, want.right_fwd, want.right_rev,
                        want.obstacle, want.distance, want.strobe);
               $display("  actual   lf=%0b lr=%0b rf=%0b rr=%0b obst=%0b dist=%0d stb=%0b",
                        got.left_fwd, got.left_rev, got.right_fwd, got.right_rev,
                        got.obstacle, got.distance, got.strobe);
            end
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [2:0]              req_sensor_sample_a;
   logic [2:0]              req_sensor_sample_b;
   logic [15:0]             req_echo_start;
   logic [15:0]             req_echo_end;
   logic                    req_echo_ok;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_left_forward;
   logic                    rsp_left_reverse;
   logic                    rsp_right_forward;
   logic                    rsp_right_reverse;
   logic                    rsp_obstacle;
   logic [8:0]              rsp_distance_out;
   logic                    rsp_range_strobe;
   logic                    csr_write_enable;
   csr_index_type           csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;

   bridge_pin_tracker_type pins_sb;
   tick_cfg_type           cur_cfg;
   int                     cycle_count = 0;
   bit                     tx_idle_on;
   bit                     rx_idle_on;
   bit                     hold_request = 1'b0;
   int                     hold_left = 0;
   int                     rx_gap_left = 0;
   logic [2:0]             run_line = '0;
   int                     run_left = 0;

   line_follow_motor_tick_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sensor_sample_a (req_sensor_sample_a),
      .req_sensor_sample_b (req_sensor_sample_b),
      .req_echo_start      (req_echo_start),
      .req_echo_end        (req_echo_end),
      .req_echo_ok         (req_echo_ok),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_forward    (rsp_left_forward),
      .rsp_left_reverse    (rsp_left_reverse),
      .rsp_right_forward   (rsp_right_forward),
      .rsp_right_reverse   (rsp_right_reverse),
      .rsp_obstacle        (rsp_obstacle),
      .rsp_distance_out    (rsp_distance_out),
      .rsp_range_strobe    (rsp_range_strobe),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial clock = 1'b0;
   always #6ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL line_follow_motor_tick_top");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         pins_sb.match_pins({rsp_left_forward, rsp_left_reverse, rsp_right_forward,
                             rsp_right_reverse, rsp_obstacle, rsp_distance_out,
                             rsp_range_strobe});
      end
   end

   // hold off the result side in bursts, or for one long stretch on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            rsp_ready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic put_reg(csr_index_type idx, logic [9:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= v;
      pins_sb.set_reg(idx, v);
      @(negedge clock);
   endtask

   task automatic apply_cfg(tick_cfg_type c);
      put_reg(CSR_PWM_PERIOD, 10'(c.pwm_period));
      put_reg(CSR_STOP_THRESHOLD, 10'(c.stop_cm));
      put_reg(CSR_RANGE_MIN, 10'(c.min_cm));
      put_reg(CSR_RANGE_MAX, 10'(c.max_cm));
      put_reg(CSR_RANGE_INTERVAL, c.range_every);
      put_reg(CSR_CONTROL_INTERVAL, 10'(c.steer_every));
      put_reg(CSR_RECOVERY_LIMIT, c.lost_limit);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      cur_cfg = c;
   endtask

   function automatic tick_cfg_type roll_cfg();
      tick_cfg_type c;
      c.pwm_period  = 8'($urandom_range(1, 255));
      c.stop_cm     = 9'($urandom_range(0, 200));
      c.min_cm      = 9'($urandom_range(0, 40));
      c.max_cm      = 9'($urandom_range(100, 511));
      c.range_every = 10'($urandom_range(1, 8));
      c.steer_every = 4'($urandom_range(1, 4));
      c.lost_limit  = 10'($urandom_range(0, 12));
      return c;
   endfunction

   // lines come in runs so that lost-line stretches reach the search spin
   function automatic tick_req_type roll_tick();
      tick_req_type t;
      int           sel;
      int           cm_goal;
      logic [15:0]  dur;
      if (run_left == 0) begin
         if ($urandom_range(0, 9) < 3) begin
            run_line = 3'd0;
            run_left = $urandom_range(1, 30);
         end else begin
            run_line = 3'($urandom_range(1, 7));
            run_left = $urandom_range(1, 8);
         end
      end
      run_left--;
      if ($urandom_range(0, 15) == 0) begin
         t.sample_a = 3'($urandom);
         t.sample_b = 3'($urandom);
      end else begin
         t.sample_a = ~run_line;
         t.sample_b = ~run_line;
         for (int i = 0; i < 3; i++) begin
            if (run_line[i]) begin
               case ($urandom_range(0, 2))
                  0: t.sample_a[i] = 1'b1;
                  1: t.sample_b[i] = 1'b1;
                  default: ;
               endcase
            end
         end
      end
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2, 3: cm_goal = int'(cur_cfg.stop_cm) + int'($urandom_range(0, 4)) - 2;
         4:          cm_goal = int'(cur_cfg.min_cm) - int'($urandom_range(0, 1));
         5:          cm_goal = int'(cur_cfg.max_cm) + int'($urandom_range(0, 1));
         default:    cm_goal = $urandom_range(0, 1100);
      endcase
      if (cm_goal < 0) cm_goal = 0;
      dur          = 16'(cm_goal * 58 + $urandom_range(0, 57));
      t.echo_start = 16'($urandom);
      t.echo_end   = t.echo_start + dur;
      t.echo_ok    = (sel != 8);
      if (sel == 9) begin
         t.echo_end = 16'($urandom);
         t.echo_ok  = 1'($urandom_range(0, 1));
      end
      return t;
   endfunction

   task automatic send_tick(tick_req_type t);
      req_valid           <= 1'b1;
      req_sensor_sample_a <= t.sample_a;
      req_sensor_sample_b <= t.sample_b;
      req_echo_start      <= t.echo_start;
      req_echo_end        <= t.echo_end;
      req_echo_ok         <= t.echo_ok;
      do @(posedge clock); while (!req_ready);
      pins_sb.take_tick(t);
      @(negedge clock);
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic send_raw(logic [2:0] a, logic [2:0] b, logic [15:0] s, logic [15:0] e,
                           logic ok);
      send_tick('{a, b, s, e, ok});
   endtask

   task automatic send_cm(logic [2:0] a, logic [2:0] b, int cm);
      send_raw(a, b, 16'h0100, 16'(16'h0100 + cm * 58), 1'b1);
   endtask

   task automatic run_random(int n);
      repeat (n) send_tick(roll_tick());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pins_sb.pin_queue.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      pins_sb             = new();
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_sensor_sample_a = '0;
      req_sensor_sample_b = '0;
      req_echo_start      = '0;
      req_echo_end        = '0;
      req_echo_ok         = 1'b0;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_PWM_PERIOD;
      csr_write_data      = '0;
      tx_idle_on          = 1'b1;
      rx_idle_on          = 1'b1;
      cur_cfg = '{PWM_PERIOD_RESET, STOP_THRESHOLD_RESET, RANGE_MIN_RESET, RANGE_MAX_RESET,
                  RANGE_INTERVAL_RESET, CONTROL_INTERVAL_RESET, RECOVERY_LIMIT_RESET};
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_random(60);
      drain();

      apply_cfg('{8'd255, 9'd30, 9'd5, 9'd300, 10'd1, 4'd1, 10'd2});
      send_cm(3'b111, 3'b111, 100);
      send_raw(3'b101, 3'b101, 16'h0100, 16'h2000, 1'b0);
      send_cm(3'b011, 3'b111, 5);
      send_raw(3'b111, 3'b110, 16'h0100, 16'(16'h0100 + 300 * 58 + 57), 1'b1);
      send_cm(3'b001, 3'b111, 4);
      send_cm(3'b100, 3'b110, 301);
      send_raw(3'b010, 3'b010, 16'hF000, 16'h1000, 1'b1);
      send_cm(3'b000, 3'b000, 50);
      repeat (3) send_cm(3'b111, 3'b111, 50);
      send_cm(3'b110, 3'b110, 50);
      send_cm(3'b111, 3'b111, 50);
      send_cm(3'b101, 3'b101, 50);
      send_cm(3'b111, 3'b111, 50);
      send_cm(3'b011, 3'b011, 10);
      repeat (3) send_cm(3'b111, 3'b111, 10);
      send_raw(3'b111, 3'b111, 16'h0000, 16'hFFFF, 1'b1);
      send_raw(3'b000, 3'b000, 16'h5555, 16'h5555, 1'b1);
      send_raw(3'b111, 3'b111, 16'hFFFF, 16'h0000, 1'b1);
      send_cm(3'b101, 3'b101, 29);
      send_cm(3'b101, 3'b101, 30);
      drain();

      apply_cfg('{8'd100, 9'd20, 9'd2, 9'd400, 10'd3, 4'd2, 10'd5});
      run_random(60);
      drain();

      apply_cfg('{8'd1, 9'd511, 9'd0, 9'd511, 10'd1, 4'd1, 10'd0});
      run_random(60);
      drain();

      apply_cfg('{8'd255, 9'd0, 9'd511, 9'd0, 10'd1023, 4'd15, 10'd1023});
      run_random(60);
      drain();

      apply_cfg(roll_cfg());
      run_random(30);
      hold_request = 1'b1;
      run_random(50);
      drain();

      apply_cfg(roll_cfg());
      run_random(50);
      drain();

      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      apply_cfg(roll_cfg());
      run_random(60);
      drain();
      repeat (8) @(negedge clock);

      $display("covered %0d ticks over eight settings: %0d range updates, %0d stops on obstacle,",
               pins_sb.ticks, pins_sb.strobes, pins_sb.blocked);
      $display("%0d search spins, %0d mismatching beats", pins_sb.spins, pins_sb.pin_errors);
      if (pins_sb.pin_errors == 0 && pins_sb.pin_queue.size() == 0) begin
         $display("PASS line_follow_motor_tick_top");
      end else begin
         $display("FAIL line_follow_motor_tick_top");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lfmt_pkg.sv
hw/rtl/line_follow_motor_tick_top.sv
test/line_follow_motor_tick_top_tb.sv
